### hdl/rfbm_pkg.sv
// rfbm_pkg: shared types and constants for the register file with bus muxes
// holds the command beat struct, write-enable bit positions and bus select codes
// no dependencies
`timescale 1ns / 1ps

package rfbm_pkg;

    localparam int unsigned MASK_W = 25;
    localparam int unsigned IDX_W  = 5;

    // write-enable bit positions
    localparam int unsigned WE_AH   = 0;
    localparam int unsigned WE_DIH  = 8;
    localparam int unsigned WE_SPH  = 14;
    localparam int unsigned WE_SPL  = 15;
    localparam int unsigned WE_TDRH = 16;
    localparam int unsigned WE_TDRL = 17;
    localparam int unsigned WE_PCH  = 18;
    localparam int unsigned WE_PCL  = 19;
    localparam int unsigned WE_MASK = 20;
    localparam int unsigned WE_MDRL = 21;
    localparam int unsigned WE_MDRH = 22;
    localparam int unsigned WE_MARL = 23;
    localparam int unsigned WE_MARH = 24;

    // w bus rows
    localparam logic [1:0] ROW_GEN  = 2'd0;
    localparam logic [1:0] ROW_PTR  = 2'd1;
    localparam logic [1:0] ROW_WORD = 2'd2;
    localparam logic [1:0] ROW_SYS  = 2'd3;

    // row 3 columns
    localparam logic [2:0] COL_SSPL   = 3'd0;
    localparam logic [2:0] COL_SSPH   = 3'd1;
    localparam logic [2:0] COL_VECTOR = 3'd2;
    localparam logic [2:0] COL_IMASK  = 3'd3;
    localparam logic [2:0] COL_STATUS = 3'd4;

    // row 2 register pairs
    localparam logic [1:0] PAIR_PC  = 2'd0;
    localparam logic [1:0] PAIR_MAR = 2'd1;
    localparam logic [1:0] PAIR_MDR = 2'd2;
    localparam logic [1:0] PAIR_TDR = 2'd3;

    // k bus selects
    localparam logic [1:0] KSEL_MDRL = 2'd0;
    localparam logic [1:0] KSEL_MDRH = 2'd1;
    localparam logic [1:0] KSEL_TDRL = 2'd2;
    localparam logic [1:0] KSEL_TDRH = 2'd3;

    typedef struct packed {
        logic [MASK_W-1:0] write_mask;
        logic [7:0]        z_bus;
        logic [7:0]        ext_data;
        logic              mdr_from_data;
        logic              mar_from_pc;
        logic              user_mode;
        logic [IDX_W-1:0]  w_index;
        logic [1:0]        k_select;
        logic [7:0]        interrupt_vector;
        logic [7:0]        interrupt_status;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  w_bus_value;
        logic [7:0]  k_bus_value;
        logic [15:0] memory_address;
        logic [15:0] memory_data;
    } result_t;

endpackage

### hdl/cpu_register_file_with_bus_muxes_top.sv
// cpu_register_file_with_bus_muxes_top: cpu register file with w and k read buses
// instantiates rfbm_in_stage, rfbm_core and rfbm_out_stage; uses rfbm_pkg
//
//  channel   handshake        payload
//  command   start / busy     write_mask .. interrupt_status
//  result    done (strobe)    w_bus_value, k_bus_value, memory_address, memory_data
//
// one command beat per cycle; busy is always low
// a result strobes done once its start beat has passed the input register, then
// the register file update and read muxes, then the result register
// reset clears all architectural registers to zero and drops pending beats
// results cannot be stalled; each is shown for one cycle and held until the next
`timescale 1ns / 1ps

module cpu_register_file_with_bus_muxes_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [24:0] write_mask,
    input  logic [7:0]  z_bus,
    input  logic [7:0]  ext_data,
    input  logic        mdr_from_data,
    input  logic        mar_from_pc,
    input  logic        user_mode,
    input  logic        read_from_panel,
    input  logic [4:0]  panel_index,
    input  logic [4:0]  ucode_index,
    input  logic [1:0]  k_select,
    input  logic [7:0]  interrupt_vector,
    input  logic [7:0]  interrupt_status,
    output logic        done,
    output logic [7:0]  w_bus_value,
    output logic [7:0]  k_bus_value,
    output logic [15:0] memory_address,
    output logic [15:0] memory_data
);
    import rfbm_pkg::*;

    logic    cmd_valid;
    cmd_t    cmd;
    result_t result;

    assign busy = 1'b0;

    rfbm_in_stage u_in (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (start & ~busy),
        .write_mask       (write_mask),
        .z_bus            (z_bus),
        .ext_data         (ext_data),
        .mdr_from_data    (mdr_from_data),
        .mar_from_pc      (mar_from_pc),
        .user_mode        (user_mode),
        .read_from_panel  (read_from_panel),
        .panel_index      (panel_index),
        .ucode_index      (ucode_index),
        .k_select         (k_select),
        .interrupt_vector (interrupt_vector),
        .interrupt_status (interrupt_status),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd)
    );

    rfbm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .result    (result)
    );

    rfbm_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (cmd_valid),
        .result         (result),
        .done           (done),
        .w_bus_value    (w_bus_value),
        .k_bus_value    (k_bus_value),
        .memory_address (memory_address),
        .memory_data    (memory_data)
    );

endmodule

### hdl/rfbm_in_stage.sv
// rfbm_in_stage: input register for one micro-cycle command beat
// resolves the w bus index source before registering; uses rfbm_pkg
`timescale 1ns / 1ps

module rfbm_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [24:0]           write_mask,
    input  logic [7:0]            z_bus,
    input  logic [7:0]            ext_data,
    input  logic                  mdr_from_data,
    input  logic                  mar_from_pc,
    input  logic                  user_mode,
    input  logic                  read_from_panel,
    input  logic [4:0]            panel_index,
    input  logic [4:0]            ucode_index,
    input  logic [1:0]            k_select,
    input  logic [7:0]            interrupt_vector,
    input  logic [7:0]            interrupt_status,
    output logic                  cmd_valid,
    output rfbm_pkg::cmd_t        cmd
);
    import rfbm_pkg::*;

    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    always_comb
    begin
        cmd_next.write_mask       = write_mask;
        cmd_next.z_bus            = z_bus;
        cmd_next.ext_data         = ext_data;
        cmd_next.mdr_from_data    = mdr_from_data;
        cmd_next.mar_from_pc      = mar_from_pc;
        cmd_next.user_mode        = user_mode;
        cmd_next.w_index          = read_from_panel ? panel_index : ucode_index;
        cmd_next.k_select         = k_select;
        cmd_next.interrupt_vector = interrupt_vector;
        cmd_next.interrupt_status = interrupt_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

### hdl/rfbm_core.sv
// rfbm_core: architectural registers, byte write decode and the w/k read muxes
// w/k reads see pre-write values, memory outputs post-write ones; uses rfbm_pkg
`timescale 1ns / 1ps

module rfbm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  rfbm_pkg::cmd_t       cmd,
    output rfbm_pkg::result_t    result
);
    import rfbm_pkg::*;

    logic [7:0]  gen_reg [8];
    logic [7:0]  gen_next [8];
    logic [7:0]  ptr_reg [8];
    logic [7:0]  ptr_next [8];
    logic [15:0] pc_reg, pc_next;
    logic [15:0] mar_reg, mar_next;
    logic [15:0] mdr_reg, mdr_next;
    logic [15:0] tdr_reg, tdr_next;
    logic [15:0] ssp_reg, ssp_next;
    logic [7:0]  imask_reg, imask_next;

    logic [24:0] we;
    logic [7:0]  z;
    logic [7:0]  mdr_src;
    logic [1:0]  row;
    logic [2:0]  col;
    logic [15:0] pair_word;
    logic [7:0]  w_val;
    logic [7:0]  k_val;

    assign we  = cmd_valid ? cmd.write_mask : '0;
    assign z   = cmd.z_bus;
    assign row = cmd.w_index[4:3];
    assign col = cmd.w_index[2:0];

    // write decode
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            // even bit is the high byte, odd bit the low byte
            gen_next[2*i+1] = we[WE_AH+2*i]   ? z : gen_reg[2*i+1];
            gen_next[2*i]   = we[WE_AH+2*i+1] ? z : gen_reg[2*i];
            // mask order runs DI, SI, BP, SP against storage order SP, BP, SI, DI
            ptr_next[2*(3-i)+1] = we[WE_DIH+2*i]   ? z : ptr_reg[2*(3-i)+1];
            ptr_next[2*(3-i)]   = we[WE_DIH+2*i+1] ? z : ptr_reg[2*(3-i)];
        end

        ssp_next = ssp_reg;
        if (!cmd.user_mode && we[WE_SPH])
        begin
            ssp_next[15:8] = z;
        end
        if (!cmd.user_mode && we[WE_SPL])
        begin
            ssp_next[7:0] = z;
        end

        tdr_next = {we[WE_TDRH] ? z : tdr_reg[15:8], we[WE_TDRL] ? z : tdr_reg[7:0]};
        pc_next  = {we[WE_PCH] ? z : pc_reg[15:8], we[WE_PCL] ? z : pc_reg[7:0]};
        imask_next = we[WE_MASK] ? z : imask_reg;

        mdr_src  = cmd.mdr_from_data ? cmd.ext_data : z;
        mdr_next = {we[WE_MDRH] ? mdr_src : mdr_reg[15:8],
                    we[WE_MDRL] ? mdr_src : mdr_reg[7:0]};

        // mar copies the pc as updated in this same beat
        mar_next = mar_reg;
        if (we[WE_MARL])
        begin
            mar_next[7:0] = cmd.mar_from_pc ? pc_next[7:0] : z;
        end
        if (we[WE_MARH])
        begin
            mar_next[15:8] = cmd.mar_from_pc ? pc_next[15:8] : z;
        end
    end

    // w bus mux
    always_comb
    begin
        case (col[2:1])
            PAIR_PC:  pair_word = pc_reg;
            PAIR_MAR: pair_word = mar_reg;
            PAIR_MDR: pair_word = mdr_reg;
            PAIR_TDR: pair_word = tdr_reg;
            default:  pair_word = tdr_reg;
        endcase

        case (row)
            ROW_GEN:  w_val = gen_reg[col];
            ROW_PTR:  w_val = ptr_reg[col];
            ROW_WORD: w_val = col[0] ? pair_word[15:8] : pair_word[7:0];
            ROW_SYS:
            begin
                case (col)
                    COL_SSPL:   w_val = ssp_reg[7:0];
                    COL_SSPH:   w_val = ssp_reg[15:8];
                    COL_VECTOR: w_val = cmd.interrupt_vector;
                    COL_IMASK:  w_val = imask_reg;
                    COL_STATUS: w_val = cmd.interrupt_status;
                    default:    w_val = 8'd0;   // unused system columns read zero
                endcase
            end
            default:  w_val = 8'd0;
        endcase
    end

    // k bus mux
    always_comb
    begin
        case (cmd.k_select)
            KSEL_MDRL: k_val = mdr_reg[7:0];
            KSEL_MDRH: k_val = mdr_reg[15:8];
            KSEL_TDRL: k_val = tdr_reg[7:0];
            KSEL_TDRH: k_val = tdr_reg[15:8];
            default:   k_val = tdr_reg[15:8];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                gen_reg[i] <= 8'd0;
                ptr_reg[i] <= 8'd0;
            end
            pc_reg    <= 16'd0;
            mar_reg   <= 16'd0;
            mdr_reg   <= 16'd0;
            tdr_reg   <= 16'd0;
            ssp_reg   <= 16'd0;
            imask_reg <= 8'd0;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                gen_reg[i] <= gen_next[i];
                ptr_reg[i] <= ptr_next[i];
            end
            pc_reg    <= pc_next;
            mar_reg   <= mar_next;
            mdr_reg   <= mdr_next;
            tdr_reg   <= tdr_next;
            ssp_reg   <= ssp_next;
            imask_reg <= imask_next;
        end
    end

    assign result.w_bus_value    = w_val;
    assign result.k_bus_value    = k_val;
    assign result.memory_address = mar_next;
    assign result.memory_data    = mdr_next;

endmodule

### hdl/rfbm_out_stage.sv
// rfbm_out_stage: result register and done strobe
// holds the last result between beats; uses rfbm_pkg
`timescale 1ns / 1ps

module rfbm_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  rfbm_pkg::result_t    result,
    output logic                 done,
    output logic [7:0]           w_bus_value,
    output logic [7:0]           k_bus_value,
    output logic [15:0]          memory_address,
    output logic [15:0]          memory_data
);
    import rfbm_pkg::*;

    logic    done_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= res_valid;
            if (res_valid)
            begin
                res_reg <= result;
            end
        end
    end

    assign done           = done_reg;
    assign w_bus_value    = res_reg.w_bus_value;
    assign k_bus_value    = res_reg.k_bus_value;
    assign memory_address = res_reg.memory_address;
    assign memory_data    = res_reg.memory_data;

endmodule

### hdl/rfbm_checker.sv
// rfbm_checker: port-level assertions for the register file top level
// bound to cpu_register_file_with_bus_muxes_top; no package dependency
`timescale 1ns / 1ps

module rfbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [7:0]  w_bus_value,
    input logic [7:0]  k_bus_value,
    input logic [15:0] memory_address,
    input logic [15:0] memory_data
);

    // every accepted beat gives a result
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("accepted beat without result");

    // no result without an earlier command beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 1) && $past(rst_n, 2) && done |-> $past(start, 2))
        else $error("result without a command beat");

    // the block takes a beat every cycle
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // results change only with the strobe
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && !done |-> $stable(memory_address) && $stable(memory_data)
            && $stable(w_bus_value) && $stable(k_bus_value))
        else $error("result changed without done");

endmodule

bind cpu_register_file_with_bus_muxes_top rfbm_checker u_rfbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .w_bus_value    (w_bus_value),
    .k_bus_value    (k_bus_value),
    .memory_address (memory_address),
    .memory_data    (memory_data)
);

### tb/tb_cpu_register_file_with_bus_muxes_top.sv
// tb_cpu_register_file_with_bus_muxes_top: self-checking bench for the register file
// directed table then random micro-cycles, each beat checked against pinned values or an in-bench predictor
// depends on rfbm_pkg and cpu_register_file_with_bus_muxes_top
`timescale 1ns / 1ps

module tb_cpu_register_file_with_bus_muxes_top;

    import rfbm_pkg::*;

    localparam int N_RANDOM = 1350;
    localparam int WD_LIMIT = 200;
    localparam int DRAIN    = 4;

    localparam logic [24:0] M_NONE = 25'h0000000;
    localparam logic [24:0] M_ALL  = 25'h1FFFFFF;
    localparam logic [24:0] M_GEN  = 25'h00000FF;

    // {mdr_from_data, mar_from_pc, user_mode, read_from_panel}
    localparam logic [3:0] F_NONE     = 4'b0000;
    localparam logic [3:0] F_MDR_DATA = 4'b1000;
    localparam logic [3:0] F_MAR_PC   = 4'b0100;
    localparam logic [3:0] F_USER     = 4'b0010;
    localparam logic [3:0] F_PANEL    = 4'b0001;

    localparam logic [2:0] GEN_AL    = 3'd0;
    localparam logic [2:0] GEN_DH    = 3'd7;
    localparam logic [2:0] PTR_SPL   = 3'd0;
    localparam logic [2:0] PTR_SPH   = 3'd1;
    localparam logic [2:0] COL_RSVD5 = 3'd5;
    localparam logic [2:0] COL_RSVD6 = 3'd6;
    localparam logic [2:0] COL_RSVD7 = 3'd7;

    typedef struct packed {
        logic [24:0] mask;
        logic [7:0]  z;
        logic [7:0]  d;
        logic        mdr_d;
        logic        mar_pc;
        logic        user;
        logic        panel;
        logic [4:0]  psel;
        logic [4:0]  asrc;
        logic [1:0]  bsrc;
        logic [7:0]  vec;
        logic [7:0]  stat;
    } beat_t;

    typedef struct {
        beat_t   b;
        bit      pinned;
        result_t r;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [24:0] write_mask;
    logic [7:0]  z_bus;
    logic [7:0]  ext_data;
    logic        mdr_from_data;
    logic        mar_from_pc;
    logic        user_mode;
    logic        read_from_panel;
    logic [4:0]  panel_index;
    logic [4:0]  ucode_index;
    logic [1:0]  k_select;
    logic [7:0]  interrupt_vector;
    logic [7:0]  interrupt_status;
    logic        done;
    logic [7:0]  w_bus_value;
    logic [7:0]  k_bus_value;
    logic [15:0] memory_address;
    logic [15:0] memory_data;

    // predictor state, mirrors the reset values
    logic [7:0]  gen_byte [8];
    logic [7:0]  ptr_byte [8];
    logic [15:0] pc_reg    = '0;
    logic [15:0] mar_reg   = '0;
    logic [15:0] mdr_reg   = '0;
    logic [15:0] tdr_reg   = '0;
    logic [15:0] ssp_reg   = '0;
    logic [7:0]  imask_reg = '0;

    result_t  expected_buses [$];
    dir_row_t dir_tab [$];
    int       errs;
    int       stall_cnt;
    int       burst_left;

    cpu_register_file_with_bus_muxes_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .write_mask       (write_mask),
        .z_bus            (z_bus),
        .ext_data         (ext_data),
        .mdr_from_data    (mdr_from_data),
        .mar_from_pc      (mar_from_pc),
        .user_mode        (user_mode),
        .read_from_panel  (read_from_panel),
        .panel_index      (panel_index),
        .ucode_index      (ucode_index),
        .k_select         (k_select),
        .interrupt_vector (interrupt_vector),
        .interrupt_status (interrupt_status),
        .done             (done),
        .w_bus_value      (w_bus_value),
        .k_bus_value      (k_bus_value),
        .memory_address   (memory_address),
        .memory_data      (memory_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [24:0] bitm(input int unsigned n);
        return 25'd1 << n;
    endfunction

    // one micro-cycle: read buses from old values, then byte writes
    function automatic result_t step_register_file(input beat_t b);
        logic [4:0] idx;
        logic [2:0] col;
        logic [7:0] w;
        logic [7:0] k;
        logic [7:0] src;
        result_t    r;
        int         i;
        int         pair;
        idx = b.panel ? b.psel : b.asrc;
        col = idx[2:0];
        case (idx[4:3])
            ROW_GEN: w = gen_byte[col];
            ROW_PTR: w = ptr_byte[col];
            ROW_WORD:
            begin
                case (col[2:1])
                    PAIR_PC:  w = col[0] ? pc_reg[15:8]  : pc_reg[7:0];
                    PAIR_MAR: w = col[0] ? mar_reg[15:8] : mar_reg[7:0];
                    PAIR_MDR: w = col[0] ? mdr_reg[15:8] : mdr_reg[7:0];
                    default:  w = col[0] ? tdr_reg[15:8] : tdr_reg[7:0];
                endcase
            end
            default:
            begin
                case (col)
                    COL_SSPL:   w = ssp_reg[7:0];
                    COL_SSPH:   w = ssp_reg[15:8];
                    COL_VECTOR: w = b.vec;
                    COL_IMASK:  w = imask_reg;
                    COL_STATUS: w = b.stat;
                    default:    w = 8'h00;
                endcase
            end
        endcase
        case (b.bsrc)
            KSEL_MDRL: k = mdr_reg[7:0];
            KSEL_MDRH: k = mdr_reg[15:8];
            KSEL_TDRL: k = tdr_reg[7:0];
            default:   k = tdr_reg[15:8];
        endcase

        // mask pairs are high byte first, array slots low byte first
        for (i = 0; i < 4; i++)
        begin
            if (b.mask[WE_AH + 2*i])     gen_byte[2*i + 1] = b.z;
            if (b.mask[WE_AH + 2*i + 1]) gen_byte[2*i]     = b.z;
        end
        // DI, SI, BP, SP land in pointer pairs 3 down to 0
        for (i = 0; i < 4; i++)
        begin
            pair = 3 - i;
            if (b.mask[WE_DIH + 2*i])     ptr_byte[2*pair + 1] = b.z;
            if (b.mask[WE_DIH + 2*i + 1]) ptr_byte[2*pair]     = b.z;
        end
        if (!b.user)
        begin
            if (b.mask[WE_SPH]) ssp_reg[15:8] = b.z;
            if (b.mask[WE_SPL]) ssp_reg[7:0]  = b.z;
        end
        if (b.mask[WE_TDRH]) tdr_reg[15:8] = b.z;
        if (b.mask[WE_TDRL]) tdr_reg[7:0]  = b.z;
        if (b.mask[WE_PCH])  pc_reg[15:8]  = b.z;
        if (b.mask[WE_PCL])  pc_reg[7:0]   = b.z;
        if (b.mask[WE_MASK]) imask_reg     = b.z;
        src = b.mdr_d ? b.d : b.z;
        if (b.mask[WE_MDRL]) mdr_reg[7:0]  = src;
        if (b.mask[WE_MDRH]) mdr_reg[15:8] = src;
        // mar sees the pc as just written
        if (b.mask[WE_MARL]) mar_reg[7:0]  = b.mar_pc ? pc_reg[7:0]  : b.z;
        if (b.mask[WE_MARH]) mar_reg[15:8] = b.mar_pc ? pc_reg[15:8] : b.z;

        r.w_bus_value    = w;
        r.k_bus_value    = k;
        r.memory_address = mar_reg;
        r.memory_data    = mdr_reg;
        return r;
    endfunction

    function automatic dir_row_t mk(input logic [24:0] m, input logic [7:0] z,
                                    input logic [7:0] d, input logic [3:0] fl,
                                    input logic [4:0] ps, input logic [4:0] as,
                                    input logic [1:0] bs, input logic [7:0] vec,
                                    input logic [7:0] st, input bit pin,
                                    input result_t r);
        dir_row_t row;
        row.b = '{m, z, d, fl[3], fl[2], fl[1], fl[0], ps, as, bs, vec, st};
        row.pinned = pin;
        row.r = r;
        return row;
    endfunction

    function automatic beat_t rand_beat();
        beat_t       b;
        logic [95:0] rbits;
        logic [31:0] r32;
        rbits = {$urandom(), $urandom(), $urandom()};
        b = rbits[$bits(beat_t)-1:0];
        case ($urandom_range(0, 7))
            0: b.mask = M_NONE;
            1, 2, 3:
            begin
                b.mask = M_NONE;
                repeat ($urandom_range(1, 3)) b.mask |= bitm($urandom_range(0, 24));
            end
            4, 5:
            begin
                r32 = $urandom();
                b.mask = r32[24:0];
            end
            6:
            begin
                r32 = $urandom() & $urandom();
                b.mask = r32[24:0];
            end
            default: b.mask = M_ALL;
        endcase
        return b;
    endfunction

    task automatic drive_payload(input beat_t b);
        write_mask       <= b.mask;
        z_bus            <= b.z;
        ext_data         <= b.d;
        mdr_from_data    <= b.mdr_d;
        mar_from_pc      <= b.mar_pc;
        user_mode        <= b.user;
        read_from_panel  <= b.panel;
        panel_index      <= b.psel;
        ucode_index      <= b.asrc;
        k_select         <= b.bsrc;
        interrupt_vector <= b.vec;
        interrupt_status <= b.stat;
    endtask

    // hold the beat until taken, then record what the buses must show
    task automatic issue(input beat_t b, input bit pinned, input result_t pin_r);
        result_t pred;
        start <= 1'b1;
        drive_payload(b);
        @(posedge clk);
        while (busy) @(posedge clk);
        pred = step_register_file(b);
        expected_buses.push_back(pinned ? pin_r : pred);
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            drive_payload(rand_beat());
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        errs++;
    endtask

    task automatic chk_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        result_t e;
        if (rst_n && done)
        begin
            if (expected_buses.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                e = expected_buses.pop_front();
                chk_field("w_bus_value", {8'h00, w_bus_value}, {8'h00, e.w_bus_value});
                chk_field("k_bus_value", {8'h00, k_bus_value}, {8'h00, e.k_bus_value});
                chk_field("memory_address", memory_address, e.memory_address);
                chk_field("memory_data", memory_data, e.memory_data);
            end
        end
    end

    // watchdog: cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= WD_LIMIT)
        begin
            $display("tb_cpu_register_file_with_bus_muxes_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            gen_byte[i] = '0;
            ptr_byte[i] = '0;
        end
        errs       = 0;
        stall_cnt  = 0;
        burst_left = $urandom_range(1, 40);
        rst_n      <= 1'b0;
        start      <= 1'b0;
        drive_payload('0);

        // after reset, then everything to all ones, then the row 3 specials
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_NONE, 5'd0, {ROW_GEN, GEN_AL},
            KSEL_MDRL, 8'h00, 8'h00, 1, '{8'h00, 8'h00, 16'h0000, 16'h0000}));
        dir_tab.push_back(mk(M_ALL, 8'hFF, 8'h00, F_NONE, 5'd0, {ROW_SYS, COL_VECTOR},
            KSEL_TDRH, 8'hA5, 8'h00, 1, '{8'hA5, 8'h00, 16'hFFFF, 16'hFFFF}));
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_PANEL, {ROW_SYS, COL_RSVD5},
            {ROW_GEN, GEN_AL}, KSEL_TDRH, 8'h00, 8'h00, 1,
            '{8'h00, 8'hFF, 16'hFFFF, 16'hFFFF}));
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_NONE, 5'd0, {ROW_SYS, COL_RSVD6},
            KSEL_MDRL, 8'h00, 8'h00, 1, '{8'h00, 8'hFF, 16'hFFFF, 16'hFFFF}));
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_PANEL, {ROW_SYS, COL_RSVD7},
            {ROW_SYS, COL_VECTOR}, KSEL_MDRH, 8'hC3, 8'h00, 1,
            '{8'h00, 8'hFF, 16'hFFFF, 16'hFFFF}));
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_NONE, 5'd0, {ROW_SYS, COL_STATUS},
            KSEL_TDRL, 8'h00, 8'h5A, 1, '{8'h5A, 8'hFF, 16'hFFFF, 16'hFFFF}));
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_NONE, 5'd0, {ROW_SYS, COL_IMASK},
            KSEL_MDRL, 8'h00, 8'h00, 1, '{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF}));
        // mdr loaded from the data bus
        dir_tab.push_back(mk(bitm(WE_MDRL) | bitm(WE_MDRH), 8'h00, 8'h3C,
            F_MDR_DATA | F_PANEL, {ROW_SYS, COL_SSPL}, 5'd0, KSEL_MDRL, 8'h00, 8'h00, 1,
            '{8'hFF, 8'hFF, 16'hFFFF, 16'h3C3C}));
        // sp written in user mode leaves the supervisor stack alone
        dir_tab.push_back(mk(bitm(WE_SPH) | bitm(WE_SPL), 8'h11, 8'h00, F_USER, 5'd0,
            {ROW_PTR, PTR_SPL}, KSEL_MDRH, 8'h00, 8'h00, 1,
            '{8'hFF, 8'h3C, 16'hFFFF, 16'h3C3C}));
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_NONE, 5'd0, {ROW_SYS, COL_SSPH},
            KSEL_MDRL, 8'h00, 8'h00, 1, '{8'hFF, 8'h3C, 16'hFFFF, 16'h3C3C}));
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_NONE, 5'd0, {ROW_PTR, PTR_SPH},
            KSEL_TDRH, 8'h00, 8'h00, 0, '0));
        // mar copies the pc written in the same cycle
        dir_tab.push_back(mk(bitm(WE_PCH) | bitm(WE_PCL) | bitm(WE_MARL) | bitm(WE_MARH),
            8'h7E, 8'h00, F_MAR_PC, 5'd0, {ROW_WORD, PAIR_PC, 1'b0}, KSEL_TDRL,
            8'h00, 8'h00, 1, '{8'hFF, 8'hFF, 16'h7E7E, 16'h3C3C}));
        dir_tab.push_back(mk(bitm(WE_MARL) | bitm(WE_TDRL), 8'h00, 8'h00, F_NONE, 5'd0,
            {ROW_WORD, PAIR_MAR, 1'b0}, KSEL_TDRL, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(mk(bitm(WE_MARH), 8'h55, 8'h00, F_MAR_PC, 5'd0,
            {ROW_WORD, PAIR_MAR, 1'b1}, KSEL_TDRH, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(mk(M_GEN, 8'h00, 8'h00, F_PANEL, {ROW_GEN, GEN_DH}, 5'd0,
            KSEL_MDRL, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(mk(M_ALL, 8'h00, 8'hFF, F_NONE, 5'd0, {ROW_WORD, PAIR_TDR, 1'b1},
            KSEL_MDRH, 8'hFF, 8'hFF, 0, '0));
        dir_tab.push_back(mk(M_NONE, 8'h00, 8'h00, F_NONE, 5'd0, {ROW_WORD, PAIR_MDR, 1'b0},
            KSEL_TDRL, 8'h00, 8'h00, 0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i]) issue(dir_tab[i].b, dir_tab[i].pinned, dir_tab[i].r);
        repeat (N_RANDOM) issue(rand_beat(), 0, '0);

        start <= 1'b0;
        while (expected_buses.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errs == 0)
            $display("tb_cpu_register_file_with_bus_muxes_top OK");
        else
            $display("tb_cpu_register_file_with_bus_muxes_top NOT OK");
        $finish;
    end

endmodule
